FILE: rtl/a2m_pkg.sv
package a2m_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int IDX_W         = $clog2(ATAN_ENTRIES);

    localparam int XY_W  = 34;
    localparam int Z_W   = 33;
    localparam int ANG_W = 14;

    localparam int ANG_FULL        = 23040;
    localparam int ANG_HALF        = 11520;
    localparam int ANG_QUARTER     = 5760;
    localparam int DEG64_TO_Q30    = 292818;
    localparam int CORDIC_GAIN_Q30 = 652032874;

    typedef struct packed {
        logic signed [15:0] shift_x;
        logic signed [15:0] shift_y;
        logic signed [23:0] pivot_x;
        logic signed [23:0] pivot_y;
        logic        [15:0] zoom;
        logic               neg;
    } a2m_item_t;

    typedef struct packed {
        a2m_item_t              item;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } a2m_flow_t;

    typedef struct packed {
        logic signed [47:0] offset_y;
        logic signed [47:0] offset_x;
        logic signed [31:0] coef_yy;
        logic signed [31:0] coef_yx;
        logic signed [31:0] coef_xy;
        logic signed [31:0] coef_xx;
    } a2m_result_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(843314856);
            5'd1:    v = Z_W'(497837829);
            5'd2:    v = Z_W'(263043836);
            5'd3:    v = Z_W'(133525158);
            5'd4:    v = Z_W'(67021686);
            5'd5:    v = Z_W'(33543515);
            5'd6:    v = Z_W'(16775850);
            5'd7:    v = Z_W'(8388437);
            5'd8:    v = Z_W'(4194282);
            5'd9:    v = Z_W'(2097149);
            5'd10:   v = Z_W'(1048575);
            5'd11:   v = Z_W'(524287);
            5'd12:   v = Z_W'(262143);
            5'd13:   v = Z_W'(131071);
            5'd14:   v = Z_W'(65535);
            5'd15:   v = Z_W'(32767);
            5'd16:   v = Z_W'(16383);
            5'd17:   v = Z_W'(8191);
            5'd18:   v = Z_W'(4095);
            5'd19:   v = Z_W'(2047);
            5'd20:   v = Z_W'(1023);
            5'd21:   v = Z_W'(511);
            5'd22:   v = Z_W'(255);
            5'd23:   v = Z_W'(127);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/a2m_cell.sv
module a2m_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [a2m_pkg::IDX_W-1:0]  stage_idx,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  a2m_pkg::a2m_flow_t         in_flow,
    output logic                       out_valid,
    input  logic                       out_ready,
    output a2m_pkg::a2m_flow_t         out_flow
);

    logic                                valid_reg;
    a2m_pkg::a2m_flow_t                  flow_reg;
    a2m_pkg::a2m_flow_t                  flow_next;
    logic signed [a2m_pkg::XY_W-1:0]     x_in;
    logic signed [a2m_pkg::XY_W-1:0]     y_in;
    logic signed [a2m_pkg::XY_W-1:0]     x_sh;
    logic signed [a2m_pkg::XY_W-1:0]     y_sh;
    logic signed [a2m_pkg::Z_W-1:0]      z_in;
    logic signed [a2m_pkg::Z_W-1:0]      ang;

    always_comb begin
        x_in = in_flow.x;
        y_in = in_flow.y;
        z_in = in_flow.z;
        x_sh = x_in >>> stage_idx;
        y_sh = y_in >>> stage_idx;
        ang  = a2m_pkg::atan_q30(stage_idx);
        flow_next      = in_flow;
        if (!z_in[a2m_pkg::Z_W-1]) begin
            flow_next.x = x_in - y_sh;
            flow_next.y = y_in + x_sh;
            flow_next.z = z_in - ang;
        end else begin
            flow_next.x = x_in + y_sh;
            flow_next.y = y_in - x_sh;
            flow_next.z = z_in + ang;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_flow  = flow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            flow_reg <= flow_next;
        end
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(flow_reg))
        else $error("cell dropped or changed a stalled beat");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> in_ready)
        else $error("empty cell refused a beat");

endmodule

FILE: rtl/a2m_front.sv
module a2m_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  a2m_pkg::a2m_item_t   in_item,
    input  logic signed [15:0]   in_angle,
    output logic                 out_valid,
    input  logic                 out_ready,
    output a2m_pkg::a2m_flow_t   out_flow
);

    logic                                 v1_reg;
    logic                                 v2_reg;
    logic                                 rdy1;
    logic                                 rdy2;
    a2m_pkg::a2m_item_t                   item1_reg;
    logic signed [a2m_pkg::ANG_W-1:0]     r1_reg;
    a2m_pkg::a2m_item_t                   item1_next;
    logic signed [a2m_pkg::ANG_W-1:0]     r1_next;
    a2m_pkg::a2m_flow_t                   flow2_reg;
    logic signed [17:0]                   u;
    logic signed [17:0]                   r;
    logic signed [a2m_pkg::Z_W-1:0]       z_next;

    always_comb begin
        u = 18'(in_angle) + 18'(2 * a2m_pkg::ANG_FULL);
        if (u >= 18'(3 * a2m_pkg::ANG_FULL)) begin
            r = u - 18'(3 * a2m_pkg::ANG_FULL);
        end else if (u >= 18'(2 * a2m_pkg::ANG_FULL)) begin
            r = u - 18'(2 * a2m_pkg::ANG_FULL);
        end else if (u >= 18'(a2m_pkg::ANG_FULL)) begin
            r = u - 18'(a2m_pkg::ANG_FULL);
        end else begin
            r = u;
        end
        if (r > 18'(a2m_pkg::ANG_HALF)) begin
            r = r - 18'(a2m_pkg::ANG_FULL);
        end
        item1_next     = in_item;
        item1_next.neg = 1'b0;
        if (r > 18'(a2m_pkg::ANG_QUARTER)) begin
            r              = r - 18'(a2m_pkg::ANG_HALF);
            item1_next.neg = 1'b1;
        end else if (r < -18'(a2m_pkg::ANG_QUARTER)) begin
            r              = r + 18'(a2m_pkg::ANG_HALF);
            item1_next.neg = 1'b1;
        end
        r1_next = a2m_pkg::ANG_W'(r);
    end

    assign z_next = a2m_pkg::Z_W'(r1_reg) * a2m_pkg::Z_W'(a2m_pkg::DEG64_TO_Q30);

    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v2_reg;
    assign out_flow  = flow2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            item1_reg <= item1_next;
            r1_reg    <= r1_next;
        end
        if (rdy2 && v1_reg) begin
            flow2_reg.item <= item1_reg;
            flow2_reg.x    <= a2m_pkg::XY_W'(a2m_pkg::CORDIC_GAIN_Q30);
            flow2_reg.y    <= '0;
            flow2_reg.z    <= z_next;
        end
    end

    a_angle_folded: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (r1_reg <= a2m_pkg::ANG_W'(a2m_pkg::ANG_QUARTER))
                && (r1_reg >= -a2m_pkg::ANG_W'(a2m_pkg::ANG_QUARTER)))
        else $error("angle left the folded quarter range");

endmodule

FILE: rtl/a2m_back.sv
module a2m_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  a2m_pkg::a2m_flow_t   in_flow,
    output logic                 out_valid,
    input  logic                 out_ready,
    output a2m_pkg::a2m_result_t out_result
);

    logic [3:0]                      v_reg;
    logic [3:0]                      rdy;

    logic signed [a2m_pkg::XY_W-1:0] c1_reg, s1_reg;
    logic signed [24:0]              dx1_reg, dy1_reg;
    logic signed [23:0]              px1_reg, py1_reg;
    logic        [15:0]              zm1_reg;
    logic signed [a2m_pkg::XY_W-1:0] c1_next, s1_next;
    logic signed [24:0]              dx1_next, dy1_next;

    logic signed [50:0]              zc2_reg, zs2_reg;
    logic signed [58:0]              pcx2_reg, psy2_reg, psx2_reg, pcy2_reg;
    logic signed [23:0]              px2_reg, py2_reg;
    logic        [15:0]              zm2_reg;

    logic signed [31:0]              cxx3_reg, cyx3_reg;
    logic signed [27:0]              tx3_reg, ty3_reg;
    logic        [15:0]              zm3_reg;
    logic signed [51:0]              rcx, rcy;
    logic signed [59:0]              tsx, tsy;

    logic signed [45:0]              ox_p, oy_p;
    a2m_pkg::a2m_result_t            res4_reg;

    always_comb begin
        if (in_flow.item.neg) begin
            c1_next = -in_flow.x;
            s1_next = -in_flow.y;
        end else begin
            c1_next = in_flow.x;
            s1_next = in_flow.y;
        end
        dx1_next = 25'($signed({in_flow.item.shift_x, 8'd0})) - 25'(in_flow.item.pivot_x);
        dy1_next = 25'($signed({in_flow.item.shift_y, 8'd0})) - 25'(in_flow.item.pivot_y);
    end

    always_comb begin
        rcx = 52'(zc2_reg) + 52'sd2097152;
        rcy = 52'(zs2_reg) + 52'sd2097152;
        tsx = 60'(pcx2_reg) - 60'(psy2_reg) + 60'sd536870912;
        tsy = 60'(psx2_reg) + 60'(pcy2_reg) + 60'sd536870912;
        ox_p = 46'(tx3_reg) * 46'($signed({1'b0, zm3_reg})) + 46'sd128;
        oy_p = 46'(ty3_reg) * 46'($signed({1'b0, zm3_reg})) + 46'sd128;
    end

    assign rdy[3]     = !v_reg[3] || out_ready;
    assign rdy[2]     = !v_reg[2] || rdy[3];
    assign rdy[1]     = !v_reg[1] || rdy[2];
    assign rdy[0]     = !v_reg[0] || rdy[1];
    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[3];
    assign out_result = res4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1]) begin
                v_reg[1] <= v_reg[0];
            end
            if (rdy[2]) begin
                v_reg[2] <= v_reg[1];
            end
            if (rdy[3]) begin
                v_reg[3] <= v_reg[2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            c1_reg  <= c1_next;
            s1_reg  <= s1_next;
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
            px1_reg <= in_flow.item.pivot_x;
            py1_reg <= in_flow.item.pivot_y;
            zm1_reg <= in_flow.item.zoom;
        end
        if (rdy[1] && v_reg[0]) begin
            zc2_reg  <= $signed({1'b0, zm1_reg}) * c1_reg;
            zs2_reg  <= $signed({1'b0, zm1_reg}) * s1_reg;
            pcx2_reg <= c1_reg * dx1_reg;
            psy2_reg <= s1_reg * dy1_reg;
            psx2_reg <= s1_reg * dx1_reg;
            pcy2_reg <= c1_reg * dy1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            zm2_reg  <= zm1_reg;
        end
        if (rdy[2] && v_reg[1]) begin
            cxx3_reg <= 32'(rcx >>> 22);
            cyx3_reg <= 32'(rcy >>> 22);
            tx3_reg  <= 28'(tsx >>> 30) + 28'(px2_reg);
            ty3_reg  <= 28'(tsy >>> 30) + 28'(py2_reg);
            zm3_reg  <= zm2_reg;
        end
        if (rdy[3] && v_reg[2]) begin
            res4_reg.coef_xx  <= cxx3_reg;
            res4_reg.coef_xy  <= -cyx3_reg;
            res4_reg.coef_yx  <= cyx3_reg;
            res4_reg.coef_yy  <= cxx3_reg;
            res4_reg.offset_x <= 48'(ox_p >>> 8);
            res4_reg.offset_y <= 48'(oy_p >>> 8);
        end
    end

endmodule

FILE: rtl/affine_2d_matrix_builder.sv
// Builds the 2D affine matrix zoom * (T(pivot) * R(angle) * T(-pivot)) * T(shift)
// for each input beat and returns its four Q15.16 linear coefficients and two
// Q39.8 offsets as one output beat. Takes one beat per clock while m_tready
// does not stall the output. The path runs through two angle-reduction stages,
// one CORDIC cell per stage of the sine/cosine chain and four multiply-and-round
// stages. Every stage has its own valid bit, so empty stages keep filling while
// a finished result waits on m_tready.
module affine_2d_matrix_builder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // shift_x[15:0], shift_y[31:16], angle_deg[47:32], pivot_x[71:48],
    // pivot_y[95:72], zoom[111:96]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // coef_xx[31:0], coef_xy[63:32], coef_yx[95:64], coef_yy[127:96],
    // offset_x[175:128], offset_y[223:176]
    output logic [223:0] m_tdata
);

    a2m_pkg::a2m_item_t   s_item;
    a2m_pkg::a2m_flow_t   flow   [0:a2m_pkg::NUM_CELLS];
    logic                 fvalid [0:a2m_pkg::NUM_CELLS];
    logic                 fready [0:a2m_pkg::NUM_CELLS];
    a2m_pkg::a2m_result_t result;

    always_comb begin
        s_item.shift_x = s_tdata[15:0];
        s_item.shift_y = s_tdata[31:16];
        s_item.pivot_x = s_tdata[71:48];
        s_item.pivot_y = s_tdata[95:72];
        s_item.zoom    = s_tdata[111:96];
        s_item.neg     = 1'b0;
    end

    a2m_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .in_angle  (s_tdata[47:32]),
        .out_valid (fvalid[0]),
        .out_ready (fready[0]),
        .out_flow  (flow[0])
    );

    for (genvar g = 0; g < a2m_pkg::NUM_CELLS; g++) begin : g_cell
        a2m_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (a2m_pkg::IDX_W'(g)),
            .in_valid  (fvalid[g]),
            .in_ready  (fready[g]),
            .in_flow   (flow[g]),
            .out_valid (fvalid[g+1]),
            .out_ready (fready[g+1]),
            .out_flow  (flow[g+1])
        );
    end

    a2m_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fvalid[a2m_pkg::NUM_CELLS]),
        .in_ready   (fready[a2m_pkg::NUM_CELLS]),
        .in_flow    (flow[a2m_pkg::NUM_CELLS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = result;

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with no result waiting");

endmodule
